### src/ldyp_pkg.sv
// ----------------------------------------------------------------------------
// ldyp_pkg
// Shared widths, angle constants, the micro-rotation angle table and the
// sideband record carried along the rotation cells.
// ----------------------------------------------------------------------------
package ldyp_pkg;

  localparam int CordicStagesCfg = 24;
  localparam int Stages = (CordicStagesCfg > 32) ? 32 : CordicStagesCfg;

  localparam int FieldW = 32;
  localparam int DiffW  = 33;
  localparam int DW     = 64;
  localparam int ZW     = 27;
  localparam int SW     = 5;
  localparam int GainW  = 29;
  localparam int ProdW  = FieldW + GainW;
  localparam int YawW   = 25;
  localparam int PitchW = 24;
  localparam int PreShift = 24;

  localparam logic [GainW-1:0] GainQ28 = 29'd441798841;

  typedef logic signed [DW-1:0] vec_t;
  typedef logic signed [ZW-1:0] ang_t;

  localparam ang_t Deg90  = 27'sd5898240;
  localparam ang_t Deg180 = 27'sd11796480;
  localparam ang_t Deg360 = 27'sd23592960;

  typedef struct packed {
    logic [YawW-1:0]  yaw;
    logic [ProdW-1:0] prod;
    logic             hz;
    logic             dz_neg;
    logic             dz_zero;
  } side_t;

  function automatic ang_t atan_deg(input logic [SW-1:0] idx);
    ang_t r;
    unique case (idx)
      5'd0:  r = 27'sd2949120;
      5'd1:  r = 27'sd1740967;
      5'd2:  r = 27'sd919879;
      5'd3:  r = 27'sd466945;
      5'd4:  r = 27'sd234379;
      5'd5:  r = 27'sd117304;
      5'd6:  r = 27'sd58666;
      5'd7:  r = 27'sd29335;
      5'd8:  r = 27'sd14668;
      5'd9:  r = 27'sd7334;
      5'd10: r = 27'sd3667;
      5'd11: r = 27'sd1833;
      5'd12: r = 27'sd917;
      5'd13: r = 27'sd458;
      5'd14: r = 27'sd229;
      5'd15: r = 27'sd115;
      5'd16: r = 27'sd57;
      5'd17: r = 27'sd29;
      5'd18: r = 27'sd14;
      5'd19: r = 27'sd7;
      5'd20: r = 27'sd4;
      5'd21: r = 27'sd2;
      5'd22: r = 27'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### src/ldyp_if.sv
// ----------------------------------------------------------------------------
// ldyp_in_if / ldyp_out_if
// Valid/ready channels for eye/target items and yaw/pitch results.
// ----------------------------------------------------------------------------
interface ldyp_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] eye_x;
  logic signed [31:0] eye_y;
  logic signed [31:0] eye_z;
  logic signed [31:0] target_x;
  logic signed [31:0] target_y;
  logic signed [31:0] target_z;

  modport source (output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                  input ready);
  modport sink (input valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                output ready);
endinterface

interface ldyp_out_if;
  logic               valid;
  logic               ready;
  logic [24:0]        yaw_deg;
  logic signed [23:0] pitch_deg;

  modport source (output valid, yaw_deg, pitch_deg, input ready);
  modport sink (input valid, yaw_deg, pitch_deg, output ready);
endinterface

### src/ldyp_cordic_cell.sv
// ----------------------------------------------------------------------------
// ldyp_cordic_cell
// One vectoring micro-rotation with its output register and sideband.
// ----------------------------------------------------------------------------
module ldyp_cordic_cell import ldyp_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic [SW-1:0] shift_i,
  input  logic          valid_i,
  input  vec_t          x_i,
  input  vec_t          y_i,
  input  ang_t          z_i,
  input  side_t         side_i,
  output logic          valid_o,
  output vec_t          x_o,
  output vec_t          y_o,
  output ang_t          z_o,
  output side_t         side_o
);

  vec_t xs, ys, x_d, y_d;
  ang_t z_d, a;

  always_comb begin
    xs = x_i >>> shift_i;
    ys = y_i >>> shift_i;
    a  = atan_deg(shift_i);
    if (!y_i[DW-1]) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + a;
    end else begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - a;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o    <= x_d;
      y_o    <= y_d;
      z_o    <= z_d;
      side_o <= side_i;
    end
  end

endmodule

### src/look_direction_to_yaw_pitch_unit.sv
// ----------------------------------------------------------------------------
// look_direction_to_yaw_pitch_unit
// Converts an eye/target pair into yaw and pitch angles in degrees.
// ----------------------------------------------------------------------------
// Input channel in_i carries eye and target positions (signed Q24.8); output
// channel out_o carries yaw_deg (unsigned Q9.16, 0 to below 360) and
// pitch_deg (signed Q.16, clamped to +-90, up negative).
// The datapath is one difference stage, a row of Stages rotation cells for
// yaw, a second row of Stages cells for pitch fed by the yaw magnitude, and
// an output register.
// One item is accepted per cycle unless a receiver stall holds the pipeline.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_i.ready drops; it rises in the cycle the result transfers.
// Reset clears all valid bits; no result is pending after reset.
// ----------------------------------------------------------------------------
module look_direction_to_yaw_pitch_unit import ldyp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ldyp_in_if.sink     in_i,
  ldyp_out_if.source  out_o
);

  logic en;
  logic prep_valid_q;
  logic signed [DiffW-1:0] dx_q, dy_q, dz_q;

  logic  yv [0:Stages];
  vec_t  yx [0:Stages];
  vec_t  yy [0:Stages];
  ang_t  yz [0:Stages];
  side_t ys [0:Stages];
  logic  pv [0:Stages];
  vec_t  px [0:Stages];
  vec_t  py [0:Stages];
  ang_t  pz [0:Stages];
  side_t ps [0:Stages];

  logic               out_valid_q;
  logic [YawW-1:0]    yaw_q;
  logic signed [PitchW-1:0] pitch_q;

  assign en        = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_valid_q <= 1'b0;
    end else if (en) begin
      prep_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q <= DiffW'(in_i.target_x) - DiffW'(in_i.eye_x);
      dy_q <= DiffW'(in_i.target_y) - DiffW'(in_i.eye_y);
      dz_q <= DiffW'(in_i.target_z) - DiffW'(in_i.eye_z);
    end
  end

  // yaw row entry: prescale, fold dy < 0 by 180 degrees, scale |dz| by gain
  vec_t x0, y0;
  logic [FieldW-1:0] dz_mag;

  always_comb begin
    x0 = {{(DW-DiffW-PreShift){dy_q[DiffW-1]}}, dy_q, {PreShift{1'b0}}};
    y0 = {{(DW-DiffW-PreShift){dx_q[DiffW-1]}}, dx_q, {PreShift{1'b0}}};
    yz[0] = '0;
    if (dy_q[DiffW-1]) begin
      x0 = -x0;
      y0 = -y0;
      yz[0] = Deg180;
    end
    dz_mag = dz_q[DiffW-1] ? FieldW'(-dz_q) : FieldW'(dz_q);
    yv[0] = prep_valid_q;
    yx[0] = x0;
    yy[0] = y0;
    ys[0].yaw     = '0;
    ys[0].prod    = ProdW'(dz_mag) * ProdW'(GainQ28);
    ys[0].hz      = (dx_q == '0) && (dy_q == '0);
    ys[0].dz_neg  = dz_q[DiffW-1];
    ys[0].dz_zero = (dz_q == '0);
  end

  for (genvar k = 0; k < Stages; k++) begin : g_yaw
    ldyp_cordic_cell u_cell (
      .clk_i, .rst_ni, .en_i(en), .shift_i(SW'(k)),
      .valid_i(yv[k]), .x_i(yx[k]), .y_i(yy[k]), .z_i(yz[k]), .side_i(ys[k]),
      .valid_o(yv[k+1]), .x_o(yx[k+1]), .y_o(yy[k+1]), .z_o(yz[k+1]),
      .side_o(ys[k+1])
    );
  end

  // pitch row entry: wrap yaw, round the gain-scaled dz
  ang_t ya, yb;
  logic [ProdW-1:0] gz_mag;
  vec_t gz;

  always_comb begin
    ya = yz[Stages][ZW-1] ? yz[Stages] + Deg360 : yz[Stages];
    yb = (ya >= Deg360) ? ya - Deg360 : ya;
    gz_mag = (ys[Stages].prod + ProdW'(8)) >> 4;
    gz = vec_t'({{(DW-ProdW){1'b0}}, gz_mag});
    if (ys[Stages].dz_neg) begin
      gz = -gz;
    end
    pv[0] = yv[Stages];
    px[0] = yx[Stages];
    py[0] = gz;
    pz[0] = '0;
    ps[0] = ys[Stages];
    ps[0].yaw = yb[YawW-1:0];
  end

  for (genvar k = 0; k < Stages; k++) begin : g_pitch
    ldyp_cordic_cell u_cell (
      .clk_i, .rst_ni, .en_i(en), .shift_i(SW'(k)),
      .valid_i(pv[k]), .x_i(px[k]), .y_i(py[k]), .z_i(pz[k]), .side_i(ps[k]),
      .valid_o(pv[k+1]), .x_o(px[k+1]), .y_o(py[k+1]), .z_o(pz[k+1]),
      .side_o(ps[k+1])
    );
  end

  // negate, clamp, handle vertical and zero directions
  ang_t pn, pc;
  logic [YawW-1:0] yaw_d;
  logic signed [PitchW-1:0] pitch_d;

  always_comb begin
    pn = -pz[Stages];
    pc = pn;
    if (pn > Deg90) begin
      pc = Deg90;
    end
    if (pn < -Deg90) begin
      pc = -Deg90;
    end
    yaw_d   = ps[Stages].yaw;
    pitch_d = pc[PitchW-1:0];
    if (ps[Stages].hz) begin
      yaw_d = '0;
      if (ps[Stages].dz_zero) begin
        pitch_d = '0;
      end else if (ps[Stages].dz_neg) begin
        pitch_d = Deg90[PitchW-1:0];
      end else begin
        pitch_d = -Deg90[PitchW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= pv[Stages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      yaw_q   <= yaw_d;
      pitch_q <= pitch_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.yaw_deg   = yaw_q;
  assign out_o.pitch_deg = pitch_q;

  a_yaw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (yaw_q < YawW'(Deg360)))
    else $error("yaw out of range");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (pitch_q <= $signed(Deg90[PitchW-1:0]) &&
                     pitch_q >= -$signed(Deg90[PitchW-1:0])))
    else $error("pitch out of range");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> prep_valid_q)
    else $error("transfer lost at entry");

endmodule

### tb/look_direction_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// look_direction_checker
// Watches both channels of the yaw/pitch unit. Each input transfer is turned
// into an expected yaw/pitch pair by a bit-exact CORDIC predictor. Each output
// transfer is compared field by field with the oldest pending expectation.
// ----------------------------------------------------------------------------
module look_direction_checker import ldyp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  ldyp_in_if   in_i,
  ldyp_out_if  out_i,
  output int   error_count_o,
  output int   pending_o
);

  typedef struct {
    logic [YawW-1:0]          yaw;
    logic signed [PitchW-1:0] pitch;
  } angles_t;

  localparam longint AtanDegTable [32] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0};

  localparam longint OneDeg = 65536;

  angles_t angle_queue[$];
  int      errors = 0;

  assign error_count_o = errors;
  assign pending_o     = angle_queue.size();

  function automatic longint rotate_to_axis(longint x, longint y, output longint mag);
    longint z;
    longint xs;
    longint ys;
    z = 0;
    for (int i = 0; i < Stages; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z += AtanDegTable[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z -= AtanDegTable[i];
      end
    end
    mag = x;
    return z;
  endfunction

  function automatic angles_t look_angles(longint ex, longint ey, longint ez,
                                          longint tx, longint ty, longint tz);
    angles_t r;
    longint dx;
    longint dy;
    longint dz;
    longint yaw;
    longint pitch;
    longint h;
    longint x;
    longint y;
    longint gz;
    longint unused;
    longint unsigned mz;
    dx = tx - ex;
    dy = ty - ey;
    dz = tz - ez;
    yaw = 0;
    h = 0;
    if (dx != 0 || dy != 0) begin
      x = dy <<< 24;
      y = dx <<< 24;
      yaw = 0;
      if (x < 0) begin
        x = -x;
        y = -y;
        yaw = 180 * OneDeg;
      end
      yaw += rotate_to_axis(x, y, h);
      if (yaw < 0) yaw += 360 * OneDeg;
      if (yaw >= 360 * OneDeg) yaw -= 360 * OneDeg;
      mz = (dz < 0) ? longint'(-dz) : longint'(dz);
      gz = longint'((mz * 64'd441798841 + 64'd8) >> 4);
      if (dz < 0) gz = -gz;
      pitch = -rotate_to_axis(h, gz, unused);
      if (pitch > 90 * OneDeg) pitch = 90 * OneDeg;
      if (pitch < -90 * OneDeg) pitch = -90 * OneDeg;
    end else if (dz > 0) begin
      pitch = -90 * OneDeg;
    end else if (dz < 0) begin
      pitch = 90 * OneDeg;
    end else begin
      pitch = 0;
    end
    r.yaw   = yaw[YawW-1:0];
    r.pitch = pitch[PitchW-1:0];
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    errors++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    angles_t want;
    if (!rst_ni) begin
      angle_queue.delete();
    end else begin
      if (in_i.valid && in_i.ready) begin
        angle_queue.push_back(look_angles(in_i.eye_x, in_i.eye_y, in_i.eye_z,
                                          in_i.target_x, in_i.target_y, in_i.target_z));
      end
      if (out_i.valid && out_i.ready) begin
        if (angle_queue.size() == 0) begin
          report("unexpected result", out_i.yaw_deg, 0);
        end else begin
          want = angle_queue.pop_front();
          if (out_i.yaw_deg !== want.yaw) report("yaw_deg", out_i.yaw_deg, want.yaw);
          if (out_i.pitch_deg !== want.pitch) report("pitch_deg", out_i.pitch_deg, want.pitch);
        end
      end
    end
  end

endmodule

### tb/look_direction_to_yaw_pitch_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// look_direction_to_yaw_pitch_unit_test
// Drives eye/target items into the yaw/pitch unit in random bursts while the
// result side stalls on its own patterns, including one long hold-off that
// backs the pipeline up. Directed cases cover zero, vertical, axis-aligned and
// full-range directions; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module look_direction_to_yaw_pitch_unit_test;
  import ldyp_pkg::*;

  localparam int RandomItems = 1430;
  localparam int CycleLimit  = 400000;
  localparam int LongHold    = 400;

  typedef struct {
    logic signed [31:0] ex, ey, ez, tx, ty, tz;
  } view_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   errors;
  int   pending;
  int   cycles = 0;
  int   sent = 0;
  bit   long_hold_done = 1'b0;

  ldyp_in_if  in_ch ();
  ldyp_out_if out_ch ();

  look_direction_to_yaw_pitch_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  look_direction_checker chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_ch),
    .out_i         (out_ch),
    .error_count_o (errors),
    .pending_o     (pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: rotate stall patterns, hold off once for a long stretch.
  initial begin
    int mode;
    int hold;
    out_ch.ready = 1'b0;
    mode = 0;
    hold = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!long_hold_done && sent >= 300) begin
        long_hold_done = 1'b1;
        hold = LongHold;
      end
      if (cycles % 150 == 0) mode = $urandom_range(3);
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(9) > 2);
          2: out_ch.ready <= (cycles % 7 > 2);
          default: out_ch.ready <= ($urandom_range(9) > 7);
        endcase
      end
    end
  end

  function automatic logic signed [31:0] pick_coord();
    case ($urandom_range(9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [31:0] near(logic signed [31:0] base);
    case ($urandom_range(3))
      0: return base;
      1: return base + $signed($urandom_range(64)) - 32;
      default: return base + $signed($urandom_range(2000000)) - 1000000;
    endcase
  endfunction

  function automatic view_t random_view();
    view_t v;
    v.ex = pick_coord();
    v.ey = pick_coord();
    v.ez = pick_coord();
    if ($urandom_range(9) < 4) begin
      v.tx = pick_coord();
      v.ty = pick_coord();
      v.tz = pick_coord();
    end else begin
      v.tx = near(v.ex);
      v.ty = near(v.ey);
      v.tz = near(v.ez);
    end
    return v;
  endfunction

  function automatic view_t mk(int ex, int ey, int ez, int tx, int ty, int tz);
    view_t v;
    v.ex = ex; v.ey = ey; v.ez = ez;
    v.tx = tx; v.ty = ty; v.tz = tz;
    return v;
  endfunction

  task automatic send_view(view_t v);
    in_ch.valid    <= 1'b1;
    in_ch.eye_x    <= v.ex;
    in_ch.eye_y    <= v.ey;
    in_ch.eye_z    <= v.ez;
    in_ch.target_x <= v.tx;
    in_ch.target_y <= v.ty;
    in_ch.target_z <= v.tz;
    do @(negedge clk_i); while (!in_ch.ready);
    @(posedge clk_i);
    sent++;
  endtask

  task automatic drop_valid(int gap);
    in_ch.valid <= 1'b0;
    repeat (gap) @(posedge clk_i);
  endtask

  // Sample the pending count away from the edge that pushes into it.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  initial begin
    view_t directed[$];
    int burst;
    in_ch.valid = 1'b0;
    in_ch.eye_x = 0; in_ch.eye_y = 0; in_ch.eye_z = 0;
    in_ch.target_x = 0; in_ch.target_y = 0; in_ch.target_z = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed.push_back(mk(0, 0, 0, 0, 0, 0));
    directed.push_back(mk(5, 5, 5, 5, 5, 9));
    directed.push_back(mk(5, 5, 9, 5, 5, 5));
    directed.push_back(mk(0, 0, 0, 0, 256, 0));
    directed.push_back(mk(0, 0, 0, 256, 0, 0));
    directed.push_back(mk(0, 0, 0, 0, -256, 0));
    directed.push_back(mk(0, 0, 0, -256, 0, 0));
    directed.push_back(mk(0, 0, 0, -1, -256, 0));
    directed.push_back(mk(0, 0, 0, 1, -256, 0));
    directed.push_back(mk(0, 0, 0, -1, 1, 0));
    directed.push_back(mk(0, 0, 0, 1, 1, 1000000));
    directed.push_back(mk(0, 0, 0, 1, 1, -1000000));
    directed.push_back(mk(0, 0, 0, 1000, 1000, 1));
    directed.push_back(mk(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                          32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff));
    directed.push_back(mk(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                          32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
    directed.push_back(mk(32'sh8000_0000, 0, 0, 32'sh7fff_ffff, 0, 32'sh8000_0000));
    directed.push_back(mk(0, 32'sh7fff_ffff, 0, 0, 32'sh8000_0000, 32'sh7fff_ffff));
    directed.push_back(mk(32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff,
                          32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
    directed.push_back(mk(-1, -1, -1, -1, -1, -1));
    directed.push_back(mk(0, 0, 0, 1, 0, 0));
    foreach (directed[i]) send_view(directed[i]);
    drain();

    for (int n = 0; n < RandomItems; n++) begin
      if (burst == 0) begin
        burst = $urandom_range(40, 1);
        if ($urandom_range(2) != 0) drop_valid($urandom_range(12, 1));
      end
      burst--;
      if (n == RandomItems / 2) drain();
      send_view(random_view());
    end

    drain();
    repeat (2 * Stages + 10) @(posedge clk_i);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### files.f
src/ldyp_pkg.sv
src/ldyp_if.sv
src/ldyp_cordic_cell.sv
src/look_direction_to_yaw_pitch_unit.sv
tb/look_direction_checker.sv
tb/look_direction_to_yaw_pitch_unit_test.sv
